// ===== sv/dtq_pkg.sv =====
package dtq_pkg;

    // Sizing of the queue and of the item fields.
    localparam int QUEUE_SLOTS = 16;
    localparam int TIME_BITS   = 32;
    localparam int PRIO_BITS   = 8;
    localparam int TASK_BITS   = 4;
    localparam int TASK_SLOTS  = 1 << TASK_BITS;
    localparam int IDX_BITS    = $clog2(QUEUE_SLOTS);
    localparam int COUNT_BITS  = $clog2(QUEUE_SLOTS + 1);

    // Request kinds.
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_ADD      = 2'd1;
    localparam logic [1:0] REQ_POLL     = 2'd2;
    localparam logic [1:0] REQ_COMPLETE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FIRED  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [TASK_BITS-1:0] task_id;
        logic [TIME_BITS-1:0] due_ms;
        logic [PRIO_BITS-1:0] priority_req;
        logic [TIME_BITS-1:0] interval;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [TASK_BITS-1:0]  fired_task;
        logic [TIME_BITS-1:0]  fired_due;
        logic [COUNT_BITS-1:0] queue_count;
        logic [TIME_BITS-1:0]  now_time;
    } rsp_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] due;
        logic [PRIO_BITS-1:0] prio;
        logic [TASK_BITS-1:0] task_id;
    } entry_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        entry_t              data;
    } ram_wr_t;

endpackage

// ===== sv/dtq_entry_ram.sv =====
module dtq_entry_ram (
    input  logic                          clk,
    input  dtq_pkg::ram_wr_t              wr,
    input  logic                          rd_en,
    input  logic [dtq_pkg::IDX_BITS-1:0]  rd_addr,
    output dtq_pkg::entry_t               rd_data
);
    import dtq_pkg::*;

    entry_t mem [QUEUE_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/dtq_order_cmp.sv =====
module dtq_order_cmp (
    input  dtq_pkg::entry_t                entry,
    input  logic [dtq_pkg::TIME_BITS-1:0]  key_due,
    input  logic [dtq_pkg::PRIO_BITS-1:0]  key_prio,
    input  logic                           tie_wins,
    output logic                           key_first
);
    import dtq_pkg::*;

    // The key goes ahead of the entry when the entry is due later, or, with
    // the tie rule on, when both are due together and the entry's priority
    // is not higher.
    always_comb
    begin
        key_first = (entry.due > key_due) ||
                    (tie_wins && (entry.due == key_due) && (entry.prio <= key_prio));
    end

endmodule

// ===== sv/deadline_timer_queue.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   dtq_pkg::req_t (one request)
// rsp       out        rsp_valid/rsp_stall   dtq_pkg::rsp_t (one result per request)
//
// A tick, a rejected request or a poll of an empty queue goes straight to S_FINISH; any other poll
// first checks the head of the list in S_POLL_CHK.
// An add or a reinsert into a non-empty queue walks the entry memory from the tail of the list in
// S_INS_SCAN: one entry is read, compared and moved per cycle.
// Reset (rst_n, asynchronous) empties the queue, zeroes the counter and drops any pending task.
// A stalled result sits in the output register while the next request is accepted.
module deadline_timer_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  dtq_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dtq_pkg::rsp_t   rsp
);
    import dtq_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_ISSUE = 3'd1;
    localparam logic [2:0] S_INS_SCAN  = 3'd2;
    localparam logic [2:0] S_INS_PUT   = 3'd3;
    localparam logic [2:0] S_POLL_CHK  = 3'd4;
    localparam logic [2:0] S_FINISH    = 3'd5;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_SLOTS);
    localparam logic [IDX_BITS-1:0]   LAST_IDX   = IDX_BITS'(QUEUE_SLOTS - 1);

    // The sorted list lives in a ring: logical position k sits at physical
    // slot (head + k) modulo the depth. A pop only advances the head.
    function automatic logic [IDX_BITS-1:0] phys_idx(
        input logic [IDX_BITS-1:0]   head,
        input logic [COUNT_BITS-1:0] k
    );
        logic [COUNT_BITS:0] s;
        s = (COUNT_BITS + 1)'(head) + (COUNT_BITS + 1)'(k);
        if (s >= (COUNT_BITS + 1)'(QUEUE_SLOTS))
        begin
            s = s - (COUNT_BITS + 1)'(QUEUE_SLOTS);
        end
        return s[IDX_BITS-1:0];
    endfunction

    logic [2:0]            state_reg, state_next;
    entry_t                key_reg, key_next;
    logic [1:0]            status_reg, status_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [IDX_BITS-1:0]   head_reg, head_next;
    logic [TIME_BITS-1:0]  time_reg, time_next;
    logic                  pend_valid_reg, pend_valid_next;
    entry_t                pend_reg, pend_next;
    logic [TASK_SLOTS-1:0] queued_reg, queued_next;
    logic [IDX_BITS-1:0]   scan_reg, scan_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    ram_wr_t               ram_wr;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    entry_t                rd_data;

    logic [TIME_BITS-1:0]  cmp_due;
    logic                  cmp_tie;
    logic                  key_first;

    dtq_entry_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The one comparator serves both the insertion walk and the due check of
    // a poll. For a poll the key is the counter and ties count as due.
    assign cmp_due = (state_reg == S_POLL_CHK) ? time_reg : key_reg.due;
    assign cmp_tie = (state_reg != S_POLL_CHK);

    dtq_order_cmp u_cmp (
        .entry     (rd_data),
        .key_due   (cmp_due),
        .key_prio  (key_reg.prio),
        .tie_wins  (cmp_tie),
        .key_first (key_first)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        time_next       = time_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        queued_next     = queued_reg;
        scan_next       = scan_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ram_wr          = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ST_DONE;
                    state_next  = S_FINISH;
                    unique case (req.req_type)
                        REQ_TICK:
                        begin
                            time_next = time_reg + 1'b1;
                        end
                        REQ_ADD:
                        begin
                            // A full queue, a slot already queued, or the slot
                            // that awaits completion cannot be added.
                            if ((count_reg == FULL_COUNT) || queued_reg[req.task_id] ||
                                (pend_valid_reg && (pend_reg.task_id == req.task_id)))
                            begin
                                status_next = ST_REJECT;
                            end
                            else
                            begin
                                key_next.due     = req.due_ms;
                                key_next.prio    = req.priority_req;
                                key_next.task_id = req.task_id;
                                state_next       = S_INS_ISSUE;
                            end
                        end
                        REQ_POLL:
                        begin
                            if (pend_valid_reg)
                            begin
                                status_next = ST_REJECT;
                            end
                            else if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = S_POLL_CHK;
                            end
                        end
                        REQ_COMPLETE:
                        begin
                            if (!pend_valid_reg)
                            begin
                                status_next = ST_REJECT;
                            end
                            else
                            begin
                                pend_valid_next = 1'b0;
                                // A zero interval drops the task.
                                if ((req.interval != '0) && (count_reg < FULL_COUNT))
                                begin
                                    key_next.due     = pend_reg.due + req.interval;
                                    key_next.prio    = pend_reg.prio;
                                    key_next.task_id = pend_reg.task_id;
                                    state_next       = S_INS_ISSUE;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_REJECT;
                        end
                    endcase
                end
            end

            S_INS_ISSUE:
            begin
                if (count_reg == '0)
                begin
                    ram_wr.en                    = 1'b1;
                    ram_wr.addr                  = head_reg;
                    ram_wr.data                  = key_reg;
                    count_next                   = count_reg + 1'b1;
                    queued_next[key_reg.task_id] = 1'b1;
                    state_next                   = S_FINISH;
                end
                else
                begin
                    // Start the walk at the tail of the list.
                    rd_en      = 1'b1;
                    rd_addr    = phys_idx(head_reg, count_reg - 1'b1);
                    scan_next  = IDX_BITS'(count_reg - 1'b1);
                    state_next = S_INS_SCAN;
                end
            end

            S_INS_SCAN:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = phys_idx(head_reg, COUNT_BITS'(COUNT_BITS'(scan_reg) + 1'b1));
                if (key_first)
                begin
                    // The entry moves one place toward the tail.
                    ram_wr.data = rd_data;
                    if (scan_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = phys_idx(head_reg, COUNT_BITS'(scan_reg - 1'b1));
                        scan_next = scan_reg - 1'b1;
                    end
                end
                else
                begin
                    ram_wr.data                  = key_reg;
                    count_next                   = count_reg + 1'b1;
                    queued_next[key_reg.task_id] = 1'b1;
                    state_next                   = S_FINISH;
                end
            end

            S_INS_PUT:
            begin
                ram_wr.en                    = 1'b1;
                ram_wr.addr                  = head_reg;
                ram_wr.data                  = key_reg;
                count_next                   = count_reg + 1'b1;
                queued_next[key_reg.task_id] = 1'b1;
                state_next                   = S_FINISH;
            end

            S_POLL_CHK:
            begin
                // The head fires once the counter has reached its due time.
                if (!key_first)
                begin
                    pend_valid_next              = 1'b1;
                    pend_next                    = rd_data;
                    head_next                    = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    count_next                   = count_reg - 1'b1;
                    queued_next[rd_data.task_id] = 1'b0;
                    status_next                  = ST_FIRED;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.fired_task  = (status_reg == ST_FIRED) ? pend_reg.task_id : '0;
                    rsp_next.fired_due   = (status_reg == ST_FIRED) ? pend_reg.due : '0;
                    rsp_next.queue_count = count_reg;
                    rsp_next.now_time    = time_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            status_reg     <= ST_DONE;
            count_reg      <= '0;
            head_reg       <= '0;
            time_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            queued_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            time_reg       <= time_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            queued_reg     <= queued_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        scan_reg <= scan_next;
        rsp_reg  <= rsp_next;
    end

`ifndef NO_ASSERTIONS
    // The slot map and the fill count describe the same set of tasks.
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_reg) == int'(count_reg))
        else $error("queued slot map disagrees with the fill count");

    // A task that awaits completion is never in the list at the same time.
    a_pending_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !queued_reg[pend_reg.task_id])
        else $error("pending task is also queued");

    // The insertion walk stays inside the list and only runs with room left.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_SCAN) |->
            ((COUNT_BITS'(scan_reg) < count_reg) && (count_reg < FULL_COUNT)))
        else $error("insertion walk out of range");

    // An accepted request always keeps the sequencer busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request port not stalled after an accepted transaction");
`endif

endmodule
